>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/core/hbmc_pkg.sv
package hbmc_pkg;

    localparam int SIZE_W = 3;
    localparam int POS_W  = 6;
    localparam int ERR_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd7;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 3'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OCCUPIED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic reject;
        logic place;
        logic step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic bad_pos;
        logic occupied;
        logic stable;
    } stat_t;

endpackage

>>> rtl/core/hbmc_ctrl.sv
module hbmc_ctrl
    import hbmc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FILL = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (stat.is_clear)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (stat.bad_pos || stat.occupied)
                    begin
                        cmd.reject = 1'b1;
                    end
                    else
                    begin
                        cmd.place  = 1'b1;
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                // The fill is grown one neighbour ring per cycle until it stops changing.
                if (stat.stable)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_FILL);

endmodule

>>> rtl/core/hbmc_dp.sv
module hbmc_dp
    import hbmc_pkg::*;
#(
    parameter int MAX_SIZE = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              kind,
    input  logic [POS_W-1:0]  position,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              done,
    output logic              win,
    output logic              mover,
    output logic [ERR_W-1:0]  error
);

    localparam int N = MAX_SIZE * MAX_SIZE;

    logic [SIZE_W-1:0] size_reg;
    logic [N-1:0]      first_reg;
    logic [N-1:0]      second_reg;
    logic              turn_first_reg;
    logic [N-1:0]      fill_reg;
    logic              done_reg;
    logic              win_reg;
    logic              mover_reg;
    logic [ERR_W-1:0]  error_reg;

    logic [SIZE_W-1:0] s_eff;
    logic [SIZE_W-1:0] s_m1;
    logic [POS_W-1:0]  cell_cnt;
    logic [N-1:0]      all_m;
    logic [N-1:0]      lcol_m;
    logic [N-1:0]      rcol_m;
    logic [N-1:0]      top_m;
    logic [N-1:0]      bot_m;
    logic [N-1:0]      pos_bit;
    logic [N-1:0]      occ_all;
    logic [N-1:0]      mover_stones;
    logic [N-1:0]      nb;
    logic [N-1:0]      fill_next;
    logic              win_now;

    function automatic logic [N-1:0] col_mask(input int sz, input int col);
        logic [N-1:0] m;
        m = '0;
        for (int r = 0; r < MAX_SIZE; r++)
        begin
            if (r < sz)
            begin
                m[r * sz + col] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [N-1:0] row_mask(input int sz, input int row);
        logic [N-1:0] m;
        m = '0;
        for (int c = 0; c < MAX_SIZE; c++)
        begin
            if (c < sz)
            begin
                m[row * sz + c] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [N-1:0] all_mask(input int sz);
        logic [N-1:0] m;
        m = '0;
        for (int i = 0; i < N; i++)
        begin
            if (i < sz * sz)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    // Sizes outside the legal range are clamped to the nearest legal size.
    always_comb
    begin
        if (size_reg < SIZE_MIN)
        begin
            s_eff = SIZE_MIN;
        end
        else if (size_reg > SIZE_W'(MAX_SIZE))
        begin
            s_eff = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            s_eff = size_reg;
        end
    end

    assign s_m1     = s_eff - SIZE_W'(1);
    assign cell_cnt = POS_W'(s_eff) * POS_W'(s_eff);

    // Edge masks are constant per board size, so they reduce to a small mux.
    always_comb
    begin
        all_m  = all_mask(2);
        lcol_m = col_mask(2, 0);
        rcol_m = col_mask(2, 1);
        top_m  = row_mask(2, 0);
        bot_m  = row_mask(2, 1);
        for (int sz = 3; sz <= MAX_SIZE; sz++)
        begin
            if (s_eff == SIZE_W'(sz))
            begin
                all_m  = all_mask(sz);
                lcol_m = col_mask(sz, 0);
                rcol_m = col_mask(sz, sz - 1);
                top_m  = row_mask(sz, 0);
                bot_m  = row_mask(sz, sz - 1);
            end
        end
    end

    assign pos_bit      = N'(1) << position;
    assign occ_all      = (first_reg | second_reg) >> position;
    assign mover_stones = turn_first_reg ? first_reg : second_reg;

    assign nb = ((fill_reg & ~rcol_m) << 1)
              | ((fill_reg & ~lcol_m) >> 1)
              | (fill_reg << s_eff)
              | (fill_reg >> s_eff)
              | ((fill_reg & ~lcol_m) << s_m1)
              | ((fill_reg & ~rcol_m) >> s_m1);

    assign fill_next = (fill_reg | (nb & mover_stones)) & all_m;

    assign win_now = turn_first_reg ? (|(fill_reg & top_m) && |(fill_reg & bot_m))
                                    : (|(fill_reg & lcol_m) && |(fill_reg & rcol_m));

    assign stat.is_clear = !kind;
    assign stat.bad_pos  = (position >= cell_cnt);
    assign stat.occupied = occ_all[0];
    assign stat.stable   = (fill_next == fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= SIZE_RESET;
            first_reg      <= '0;
            second_reg     <= '0;
            turn_first_reg <= 1'b1;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.clear || cmd.reject || cmd.finish;
            if (cfg_write)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                first_reg      <= '0;
                second_reg     <= '0;
                turn_first_reg <= 1'b1;
            end
            else if (cmd.place)
            begin
                if (turn_first_reg)
                begin
                    first_reg <= first_reg | pos_bit;
                end
                else
                begin
                    second_reg <= second_reg | pos_bit;
                end
            end
            else if (cmd.finish)
            begin
                turn_first_reg <= !turn_first_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place)
        begin
            fill_reg <= pos_bit;
        end
        else if (cmd.step)
        begin
            fill_reg <= fill_next;
        end

        if (cmd.clear)
        begin
            win_reg   <= 1'b0;
            mover_reg <= 1'b0;
            error_reg <= ERR_NONE;
        end
        else if (cmd.reject)
        begin
            win_reg   <= 1'b0;
            mover_reg <= !turn_first_reg;
            error_reg <= stat.bad_pos ? ERR_RANGE : ERR_OCCUPIED;
        end
        else if (cmd.finish)
        begin
            win_reg   <= win_now;
            mover_reg <= !turn_first_reg;
            error_reg <= ERR_NONE;
        end
    end

    assign done  = done_reg;
    assign win   = win_reg;
    assign mover = mover_reg;
    assign error = error_reg;

endmodule

>>> rtl/core/hex_bitboard_move_and_connect_unit.sv
// Channel   Handshake              Ports
// command   start / busy           kind, position
// result    done (one-cycle)       win, mover, error
// config    cfg_write              cfg_data
//
// A clear, an out-of-range place or a place on an occupied cell gives its word
// in the cycle after start. A legal place sets the stone, then grows the flood
// fill one neighbour ring per cycle until it is stable, and the word follows in
// the cycle after the fill is seen stable.
// Reset empties the board, gives the turn to the first player and sets size 7.
// The receiver cannot stall; done is high for exactly one cycle per word.
`include "assert_macros.svh"

module hex_bitboard_move_and_connect_unit
    import hbmc_pkg::*;
#(
    parameter int MAX_SIZE = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [POS_W-1:0]  position,
    output logic              done,
    output logic              win,
    output logic              mover,
    output logic [ERR_W-1:0]  error,
    input  logic              cfg_write,
    input  logic [SIZE_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    hbmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    hbmc_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .position  (position),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .win       (win),
        .mover     (mover),
        .error     (error)
    );

    `ASSERT_NEVER(a_done_not_busy, done && busy, "result word while fill still running")
    `ASSERT_CLK(a_clear_result, start && !busy && !kind |=> done && !win && !mover && error == ERR_NONE, "clear did not give a clean result word")
    `ASSERT_NEVER(a_win_no_error, done && win && error != ERR_NONE, "win reported with an error code")

endmodule

>>> verif/tb_top.sv
module tb_top
    import hbmc_pkg::*;
();

    localparam int MAX_SIDE    = 7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DIR_ROWS    = 20;
    localparam int PHASE_WORDS = 144;
    localparam int NUM_PHASES  = 10;

    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    typedef struct packed {
        logic             win;
        logic             mover;
        logic [ERR_W-1:0] error;
    } word_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] pos;
        logic             typed;
        word_t            outcome;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              kind;
    logic [POS_W-1:0]  position;
    logic              done;
    logic              win;
    logic              mover;
    logic [ERR_W-1:0]  error;
    logic              cfg_write;
    logic [SIZE_W-1:0] cfg_data;

    // Model copy of the board, the turn and the size register.
    logic [63:0]       first_bb;
    logic [63:0]       second_bb;
    logic              first_turn;
    logic [SIZE_W-1:0] side_reg;
    logic              last_won;

    word_t pending_results[$];
    int    fail_count;
    int    cycle_count;
    int    words_sent;

    hex_bitboard_move_and_connect_unit #(
        .MAX_SIZE(MAX_SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .position  (position),
        .done      (done),
        .win       (win),
        .mover     (mover),
        .error     (error),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Column 3 ladder for the first player, the second player filling column 0.
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{KIND_CLEAR, 6'd0,  1'b1, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd63, 1'b1, '{1'b0, 1'b0, ERR_RANGE}},
        '{KIND_PLACE, 6'd49, 1'b1, '{1'b0, 1'b0, ERR_RANGE}},
        '{KIND_PLACE, 6'd48, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd48, 1'b1, '{1'b0, 1'b1, ERR_OCCUPIED}},
        '{KIND_PLACE, 6'd0,  1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd3,  1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd7,  1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd10, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd14, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd17, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd21, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd24, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd28, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd31, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd35, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd38, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd42, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_PLACE, 6'd45, 1'b0, '{1'b0, 1'b0, ERR_NONE}},
        '{KIND_CLEAR, 6'd0,  1'b1, '{1'b0, 1'b0, ERR_NONE}}
    };

    localparam logic [SIZE_W-1:0] PHASE_SIDES [NUM_PHASES] = '{
        3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd1, 3'd4, 3'd6, 3'd2, 3'd7
    };

    function automatic int unsigned board_side(input logic [SIZE_W-1:0] raw);
        int unsigned s;
        s = raw;
        if (s < SIZE_MIN)
            s = SIZE_MIN;
        if (s > MAX_SIDE)
            s = MAX_SIDE;
        return s;
    endfunction

    // Grows the group from the new stone one neighbour ring at a time and tests
    // whether it reaches both of the mover's edges.
    function automatic logic group_connects(input int unsigned s, input int unsigned seed,
                                            input logic [63:0] stones, input logic for_first);
        logic [63:0] on_board;
        logic [63:0] left_col;
        logic [63:0] right_col;
        logic [63:0] grown;
        logic [63:0] prior;
        logic [63:0] ring;
        logic [63:0] top_row;
        logic [63:0] bottom_row;
        int          r;
        int          iter;
        logic        changed;
        on_board  = (64'd1 << (s * s)) - 64'd1;
        left_col  = '0;
        right_col = '0;
        for (r = 0; r < s; r++)
        begin
            left_col  = left_col  | (64'd1 << (r * s));
            right_col = right_col | (64'd1 << (r * s + s - 1));
        end
        grown   = (64'd1 << seed) & stones & on_board;
        changed = 1'b1;
        iter    = 0;
        while (changed && iter < 64)
        begin
            prior = grown;
            ring  = ((grown & ~right_col) << 1)
                  | ((grown & ~left_col) >> 1)
                  | (grown << s)
                  | (grown >> s)
                  | ((grown & ~left_col) << (s - 1))
                  | ((grown & ~right_col) >> (s - 1));
            grown   = (grown | (ring & stones)) & on_board;
            changed = (grown != prior);
            iter++;
        end
        if (for_first)
        begin
            top_row    = (64'd1 << s) - 64'd1;
            bottom_row = top_row << (s * (s - 1));
            return ((grown & top_row) != 0) && ((grown & bottom_row) != 0);
        end
        return ((grown & left_col) != 0) && ((grown & right_col) != 0);
    endfunction

    task automatic predict_word(input logic k, input logic [POS_W-1:0] p, output word_t w);
        int unsigned s;
        logic [63:0] cell_bit;
        s        = board_side(side_reg);
        w.win    = 1'b0;
        w.mover  = ~first_turn;
        w.error  = ERR_NONE;
        last_won = 1'b0;
        cell_bit = 64'd1 << p;
        if (k == KIND_CLEAR)
        begin
            first_bb   = '0;
            second_bb  = '0;
            first_turn = 1'b1;
            w.mover    = 1'b0;
        end
        else if (p >= s * s)
        begin
            w.error = ERR_RANGE;
        end
        else if (((first_bb | second_bb) & cell_bit) != 0)
        begin
            w.error = ERR_OCCUPIED;
        end
        else
        begin
            if (first_turn)
            begin
                first_bb = first_bb | cell_bit;
                w.win    = group_connects(s, p, first_bb, 1'b1);
            end
            else
            begin
                second_bb = second_bb | cell_bit;
                w.win     = group_connects(s, p, second_bb, 1'b0);
            end
            first_turn = ~first_turn;
            last_won   = w.win;
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the word, with
    // start still high so that a following word can go out back to back.
    task automatic send_word(input logic k, input logic [POS_W-1:0] p,
                             input logic typed, input word_t typed_word);
        word_t w;
        start    <= 1'b1;
        kind     <= k;
        position <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(k, p, w);
        pending_results.push_back(typed ? typed_word : w);
        words_sent++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_side(input logic [SIZE_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        side_reg   = value;
    endtask

    // Mostly legal moves on empty cells so that games run to a win or a full
    // board; the rest are clears, stray positions and moves onto stones.
    task automatic random_word;
        int unsigned s;
        int unsigned cells;
        int unsigned roll;
        int unsigned pick;
        int unsigned empties;
        int unsigned i;
        logic [63:0] taken;
        s     = board_side(side_reg);
        cells = s * s;
        taken = first_bb | second_bb;
        roll  = $urandom_range(0, 99);
        empties = 0;
        for (i = 0; i < cells; i++)
            if (!taken[i])
                empties++;
        if (roll < 4 || (last_won && roll < 50) || (roll >= 17 && empties == 0))
        begin
            send_word(KIND_CLEAR, POS_W'($urandom_range(0, 63)), 1'b0, '0);
        end
        else if (roll < 12)
        begin
            send_word(KIND_PLACE, POS_W'($urandom_range(0, 63)), 1'b0, '0);
        end
        else if (roll < 17 && taken != 0)
        begin
            pick = $urandom_range(0, 63);
            while (!taken[pick])
                pick = $urandom_range(0, 63);
            send_word(KIND_PLACE, POS_W'(pick), 1'b0, '0);
        end
        else if (empties != 0)
        begin
            pick = $urandom_range(0, cells - 1);
            while (taken[pick])
                pick = $urandom_range(0, cells - 1);
            send_word(KIND_PLACE, POS_W'(pick), 1'b0, '0);
        end
        else
        begin
            send_word(KIND_PLACE, POS_W'($urandom_range(0, 63)), 1'b0, '0);
        end
    endtask

    // Every result word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: win=%0d mover=%0d error=%0d",
                       win, mover, error);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (win !== want.win)
                begin
                    $error("win: expected %0d, actual %0d", want.win, win);
                    fail_count++;
                end
                if (mover !== want.mover)
                begin
                    $error("mover: expected %0d, actual %0d", want.mover, mover);
                    fail_count++;
                end
                if (error !== want.error)
                begin
                    $error("error: expected %0d, actual %0d", want.error, error);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int ph;
        int n;
        int row;
        int idle_pct;
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = 1'b0;
        position   = '0;
        cfg_write  = 1'b0;
        cfg_data   = '0;
        fail_count = 0;
        words_sent = 0;
        first_bb   = '0;
        second_bb  = '0;
        first_turn = 1'b1;
        side_reg   = SIZE_RESET;
        last_won   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS; row++)
        begin
            send_word(DIR_TAB[row].kind, DIR_TAB[row].pos, DIR_TAB[row].typed,
                      DIR_TAB[row].outcome);
            if ($urandom_range(0, 99) < 30)
                hold_off($urandom_range(1, 4));
        end

        // The board is not cleared at a size change, so stones left at indices inside
        // the smaller board still count as occupied there.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_side(PHASE_SIDES[ph]);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (words_sent < 500)
                    idle_pct = 13;
                else if (words_sent < 980)
                    idle_pct = 66;
                else
                    idle_pct = 0;
                random_word();
                if ($urandom_range(0, 199) == 0)
                    drain();
                else if ($urandom_range(0, 99) < idle_pct)
                    hold_off($urandom_range(1, 6));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
